/* rtl/core/matrix_keypad_scanner_unit_macros.svh */
// Assertion macros for the checker file of the keypad scanner.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef MATRIX_KEYPAD_SCANNER_UNIT_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MKS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MKS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mks_pkg.sv */
package mks_pkg;

	localparam int APB_W   = 32;
	localparam int TICKS_W = 20;

	typedef enum logic [0:0] {
		REG_SCAN_MODE = 1'b0,
		REG_DEBOUNCE  = 1'b1
	} mks_reg_t;

	localparam logic [3:0]         ROWS_OPEN      = 4'hf;
	localparam logic [7:0]         DRIVE_ROWS     = 8'h0f;
	localparam logic [7:0]         DRIVE_COLS     = 8'hf0;
	localparam logic [7:0]         WALK_FIRST     = 8'h80;
	localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 20'd10000;

	typedef struct packed {
		logic               scan_mode;
		logic [TICKS_W-1:0] debounce_ticks;
	} mks_cfg_t;

	typedef struct packed {
		logic [7:0] drive;
		logic       key_ready;
		logic [3:0] key_index;
		logic       key_bad;
	} mks_result_t;

	// Returns {found, position} of the single low line in a nibble.
	function automatic logic [2:0] nibble_pos(input logic [3:0] nib);
		logic [2:0] res;
		case (nib)
			4'he:    res = {1'b1, 2'd0};
			4'hd:    res = {1'b1, 2'd1};
			4'hb:    res = {1'b1, 2'd2};
			4'h7:    res = {1'b1, 2'd3};
			default: res = 3'b000;
		endcase
		return res;
	endfunction

	function automatic logic [7:0] walk_pattern(input logic [1:0] pos);
		return ~(WALK_FIRST >> pos);
	endfunction

endpackage

/* rtl/core/mks_fsm.sv */
module mks_fsm #(
	parameter int DEBOUNCE_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          pins,
	input  mks_pkg::mks_cfg_t   cfg,
	output mks_pkg::mks_result_t result
);
	import mks_pkg::*;

	localparam int CW = (DEBOUNCE_BITS > TICKS_W) ? DEBOUNCE_BITS : TICKS_W;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_DEBOUNCE    = 3'd1,
		PH_REVERSE     = 3'd2,
		PH_WALK        = 3'd3,
		PH_REL_REVERSE = 3'd4,
		PH_REL_WALK    = 3'd5
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic [DEBOUNCE_BITS-1:0] count_q, count_d;
	logic [3:0]               row_q, row_d;
	logic [3:0]               col_q, col_d;
	logic [1:0]               walk_q, walk_d;

	logic [3:0]    rows, cols;
	logic [CW-1:0] ticks_ext, mask_ext, target, count_ext;
	logic [7:0]    drive;
	logic          report;
	logic [2:0]    row_pos, col_pos;
	logic          bad;

	assign rows = pins[3:0];
	assign cols = pins[7:4];

	// A debounce setting beyond the counter's range saturates at its maximum.
	assign ticks_ext = CW'(cfg.debounce_ticks);
	assign mask_ext  = CW'({DEBOUNCE_BITS{1'b1}});
	assign target    = (ticks_ext > mask_ext) ? mask_ext : ticks_ext;
	assign count_ext = CW'(count_q);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		row_d   = row_q;
		col_d   = col_q;
		walk_d  = walk_q;
		drive   = DRIVE_ROWS;
		report  = 1'b0;
		case (phase_q)
			PH_DEBOUNCE: begin
				if (count_ext < target) begin
					count_d = count_q + 1'b1;
				end else if (rows != ROWS_OPEN) begin
					row_d   = rows;
					walk_d  = 2'd0;
					phase_d = cfg.scan_mode ? PH_WALK : PH_REVERSE;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_REVERSE: begin
				drive   = DRIVE_COLS | {4'b0000, row_q};
				col_d   = cols;
				phase_d = PH_REL_REVERSE;
			end
			PH_WALK: begin
				drive = walk_pattern(walk_q);
				if (rows != ROWS_OPEN) begin
					col_d   = drive[7:4];
					phase_d = PH_REL_WALK;
				end else if (walk_q == 2'd3) begin
					walk_d  = 2'd0;
					phase_d = PH_IDLE;
				end else begin
					walk_d = walk_q + 2'd1;
				end
			end
			PH_REL_REVERSE: begin
				drive = DRIVE_COLS | {4'b0000, row_q};
				if (cols == ROWS_OPEN) begin
					report  = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			PH_REL_WALK: begin
				drive = walk_pattern(walk_q);
				if (rows == ROWS_OPEN) begin
					report  = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (rows != ROWS_OPEN) begin
					count_d = '0;
					phase_d = PH_DEBOUNCE;
				end
			end
		endcase
	end

	// The codes held in the release phases are those the report is built from.
	assign row_pos = nibble_pos(row_q);
	assign col_pos = nibble_pos(col_q);
	assign bad     = report && !(row_pos[2] && col_pos[2]);

	always_comb begin
		result.drive     = drive;
		result.key_ready = report;
		result.key_bad   = bad;
		result.key_index = (report && !bad) ? {row_pos[1:0], col_pos[1:0]} : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			row_q   <= ROWS_OPEN;
			col_q   <= ROWS_OPEN;
			walk_q  <= 2'd0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			row_q   <= row_d;
			col_q   <= col_d;
			walk_q  <= walk_d;
		end
	end

endmodule

/* rtl/core/matrix_keypad_scanner_unit.sv */
// 4x4 matrix keypad scanner.
// Each word on the sample channel (sample_valid/sample_ready, field pins) is
// the keypad port as read back in one tick. For every sample one word leaves on
// the result channel (result_valid/result_ready): the pattern to drive next,
// plus key_ready, key_index and key_bad when a press has completed with release.
// Samples are held in an input register; the scan state machine then updates
// and its word is captured in a result register when that register is empty
// or being emptied. One sample per cycle is sustained while the receiver
// keeps result_ready high.
// When the receiver stalls, the result word holds and one further sample is
// still taken into the input register; the sample channel then stalls too.
// Reset empties both registers and puts the scanner in its idle state, driving
// the rows; scan_mode reads 0 and debounce_ticks 10000 after reset.
// Configuration goes through the APB port: scan_mode at 0x0, debounce_ticks at
// 0x4; write them only while no word is in flight (the block does not enforce this).
module matrix_keypad_scanner_unit #(
	parameter int DEBOUNCE_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [mks_pkg::APB_W-1:0] pwdata,
	output logic [mks_pkg::APB_W-1:0] prdata,
	output logic                      pready,
	input  logic                      sample_valid,
	output logic                      sample_ready,
	input  logic [7:0]                pins,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [7:0]                drive,
	output logic                      key_ready,
	output logic [3:0]                key_index,
	output logic                      key_bad
);
	import mks_pkg::*;

	mks_cfg_t    cfg_q;
	mks_reg_t    reg_sel;
	logic        cfg_write;

	logic        valid_s1;
	logic [7:0]  pins_s1;
	logic        res_valid_q;
	mks_result_t res_q;
	mks_result_t result;
	logic        load_out;
	logic        step;

	assign pready    = 1'b1;
	assign reg_sel   = mks_reg_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_mode      <= 1'b0;
			cfg_q.debounce_ticks <= DEBOUNCE_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_SCAN_MODE: cfg_q.scan_mode      <= pwdata[0];
				REG_DEBOUNCE:  cfg_q.debounce_ticks <= pwdata[TICKS_W-1:0];
				default:       cfg_q                <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SCAN_MODE: prdata = APB_W'(cfg_q.scan_mode);
			REG_DEBOUNCE:  prdata = APB_W'(cfg_q.debounce_ticks);
			default:       prdata = '0;
		endcase
	end

	// The result register loads whenever it is empty or being emptied.
	assign load_out     = !res_valid_q || result_ready;
	assign step         = valid_s1 && load_out;
	assign sample_ready = !valid_s1 || load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (load_out) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			pins_s1 <= pins;
		end
		if (step) begin
			res_q <= result;
		end
	end

	mks_fsm #(
		.DEBOUNCE_BITS(DEBOUNCE_BITS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pins   (pins_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	assign result_valid = res_valid_q;
	assign drive        = res_q.drive;
	assign key_ready    = res_q.key_ready;
	assign key_index    = res_q.key_index;
	assign key_bad      = res_q.key_bad;

endmodule

/* rtl/core/mks_checker.sv */
`include "matrix_keypad_scanner_unit_macros.svh"

module mks_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] drive,
	input logic       key_ready,
	input logic [3:0] key_index,
	input logic       key_bad
);

	// A stalled word must stay put until the receiver takes it.
	`MKS_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(drive) && $stable(key_ready) && $stable(key_index) && $stable(key_bad), "result word changed while stalled")

	`MKS_ASSERT_SAME(a_bad_with_ready, result_valid && key_bad, key_ready, "key_bad without key_ready")

	`MKS_ASSERT_SAME(a_index_zero, result_valid && (!key_ready || key_bad), key_index == 4'd0, "key_index set without a good report")

	// A report only comes from a release phase, which never drives the idle pattern.
	`MKS_ASSERT_SAME(a_report_drive, result_valid && key_ready, drive != 8'h0f, "report while driving the idle pattern")

endmodule

bind matrix_keypad_scanner_unit mks_checker u_mks_checker (.*);
